@@ rtl/trapezoidal_step_profile_generator_defines.svh @@
// Assertion macros for the step profile generator.
// Included by RTL files that carry concurrent checks; expects i_clk and i_rst_n in scope.
`ifndef TRAPEZOIDAL_STEP_PROFILE_GENERATOR_DEFINES_SVH
`define TRAPEZOIDAL_STEP_PROFILE_GENERATOR_DEFINES_SVH

// same-cycle implication
`define TSPG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tspg check failed");

// next-cycle implication
`define TSPG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tspg check failed");

`endif

@@ rtl/tspg_pkg.sv @@
// Shared types and constants for the step profile generator.
// No dependencies; used by tspg_mul, tspg_div and the top level.
package tspg_pkg;

    // field widths
    localparam int POS_W     = 32;
    localparam int DT_W      = 16;
    localparam int VEL_W     = 21;
    localparam int STEP_W    = 18;
    localparam int FRAC_W    = 20;

    // serial arithmetic widths
    localparam int MUL_A_W   = 24;
    localparam int MUL_B_W   = 21;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int DIVR_W    = 26;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);
    localparam int DIV_CNT_W = $clog2(PROD_W);

    localparam logic [FRAC_W-1:0] US_PER_SEC = 20'd1000000;

    // opcodes
    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_STOP     = 3'd1;
    localparam logic [2:0] OP_MOVE_ABS = 3'd2;
    localparam logic [2:0] OP_MOVE_REL = 3'd3;
    localparam logic [2:0] OP_VEL_MOVE = 3'd4;
    localparam logic [2:0] OP_HOME     = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_VEL  = 2'd0;
    localparam logic [1:0] CFG_MAX_ACC  = 2'd1;
    localparam logic [1:0] CFG_HOME_SPD = 2'd2;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_POSITION = 2'd1,
        MODE_HOMING   = 2'd2,
        MODE_VELOCITY = 2'd3
    } t_mode;

endpackage

@@ rtl/tspg_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on tspg_pkg for widths.
module tspg_mul (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [tspg_pkg::MUL_A_W-1:0]       i_a,
    input  logic [tspg_pkg::MUL_B_W-1:0]       i_b,
    output logic                               o_done,
    output logic [tspg_pkg::PROD_W-1:0]        o_prod
);

    logic [tspg_pkg::PROD_W-1:0]    r_acc;
    logic [tspg_pkg::PROD_W-1:0]    r_a;
    logic [tspg_pkg::MUL_B_W-1:0]   r_b;
    logic [tspg_pkg::MUL_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;
    logic [tspg_pkg::PROD_W-1:0]    n_acc;
    logic                           w_last;

    assign n_acc  = r_b[0] ? (r_acc + r_a) : r_acc;
    assign w_last = (r_cnt == tspg_pkg::MUL_CNT_W'(tspg_pkg::MUL_B_W - 1));

    // one partial product per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && w_last;
            if (i_start) begin
                r_acc  <= '0;
                r_a    <= {{(tspg_pkg::PROD_W - tspg_pkg::MUL_A_W){1'b0}}, i_a};
                r_b    <= i_b;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_a   <= {r_a[tspg_pkg::PROD_W-2:0], 1'b0};
                r_b   <= {1'b0, r_b[tspg_pkg::MUL_B_W-1:1]};
                r_cnt <= r_cnt + 1'b1;
                if (w_last)
                    r_busy <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

@@ rtl/tspg_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on tspg_pkg for widths.
module tspg_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tspg_pkg::PROD_W-1:0]   i_num,
    input  logic [tspg_pkg::DIVR_W-1:0]   i_den,
    output logic                          o_done,
    output logic [tspg_pkg::PROD_W-1:0]   o_quo,
    output logic [tspg_pkg::DIVR_W-1:0]   o_rem
);

    logic [tspg_pkg::DIVR_W-1:0]    r_rem;
    logic [tspg_pkg::PROD_W-1:0]    r_quo;
    logic [tspg_pkg::DIVR_W-1:0]    r_den;
    logic [tspg_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;
    logic [tspg_pkg::DIVR_W:0]      w_trial;
    logic                           w_fit;
    logic                           w_last;

    assign w_trial = {r_rem, r_quo[tspg_pkg::PROD_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});
    assign w_last  = (r_cnt == tspg_pkg::DIV_CNT_W'(tspg_pkg::PROD_W - 1));

    // shift in one dividend bit, trial subtract
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && w_last;
            if (i_start) begin
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_fit ? tspg_pkg::DIVR_W'(w_trial - {1'b0, r_den})
                               : w_trial[tspg_pkg::DIVR_W-1:0];
                r_quo <= {r_quo[tspg_pkg::PROD_W-2:0], w_fit};
                r_cnt <= r_cnt + 1'b1;
                if (w_last)
                    r_busy <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

@@ rtl/trapezoidal_step_profile_generator.sv @@
// Commands: ST_LOAD puts the result in the output register, then ST_IDLE takes the next item.
// A moving tick runs serial passes, each a start, a multiply and a divide state:
// velocity step, step cap, braking distance (position mode, nonzero speed) and step count,
// plus the ramp and load states before the result reaches the output register.
// One item in work at a time; a result waits in the output register while the next is taken.
// Reset (sync, active low): mode idle, position/targets/velocity/remainder 0, limits 1000/10000.
`include "trapezoidal_step_profile_generator_defines.svh"
module trapezoidal_step_profile_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: operand[31:0], elapsed_us[47:32], home_sensor[48], home_timed_out[49], zero pad
    input  logic [55:0] s_axis_tdata,
    // tuser: opcode[2:0]
    input  logic [2:0]  s_axis_tuser,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: steps_issued[17:0], position_now[49:18], velocity_now[70:50],
    //        mode_now[72:71], move_done[73], zero pad
    output logic [79:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MSTART, ST_MUL, ST_DIV, ST_RAMP, ST_LOAD
    } t_state;

    typedef enum logic [1:0] {
        PH_DV, PH_CAP, PH_DD, PH_STEP
    } t_phase;

    t_state r_state;
    t_phase r_phase;

    // configuration
    logic [19:0] r_vmax;
    logic [23:0] r_amax;
    logic [19:0] r_hspd;

    // motion state
    tspg_pkg::t_mode    r_mode;
    logic [31:0]        r_pos;
    logic [31:0]        r_tgt;
    logic signed [20:0] r_vel;
    logic signed [20:0] r_tvel;
    logic [19:0]        r_frac;

    // per-tick working registers
    logic [15:0]        r_dt;
    logic               r_neg;
    logic [31:0]        r_mag;
    logic [20:0]        r_dv;
    logic [17:0]        r_cap;
    logic [40:0]        r_dd;
    logic               r_tneg;
    logic signed [17:0] r_steps;

    // output register
    logic [79:0] r_out_data;
    logic        r_out_valid;
    logic        w_load;

    // limits with zero read as one
    logic [19:0] w_vlim;
    logic [23:0] w_accl;
    assign w_vlim = (r_vmax == '0) ? 20'd1 : r_vmax;
    assign w_accl = (r_amax == '0) ? 24'd1 : r_amax;

    // input fields
    logic [2:0]         w_op;
    logic signed [31:0] w_operand;
    logic [15:0]        w_dt;
    logic               w_sensor;
    logic               w_tout;
    logic               w_in_acc;
    assign w_op      = s_axis_tuser;
    assign w_operand = signed'(s_axis_tdata[31:0]);
    assign w_dt      = s_axis_tdata[47:32];
    assign w_sensor  = s_axis_tdata[48];
    assign w_tout    = s_axis_tdata[49];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc  = s_axis_tvalid && s_axis_tready;

    // result moves into the output register
    assign w_load = (r_state == ST_LOAD) && (!r_out_valid || m_axis_tready);

    // remaining distance
    logic [31:0] w_rem;
    assign w_rem = r_tgt - r_pos;

    // velocity command saturated to the limit
    logic signed [32:0] w_op_ext;
    logic signed [32:0] w_lim_ext;
    logic signed [20:0] w_op_sat;
    assign w_op_ext  = {w_operand[31], w_operand};
    assign w_lim_ext = signed'({13'd0, w_vlim});
    always_comb begin
        if (w_op_ext > w_lim_ext)
            w_op_sat = signed'({1'b0, w_vlim});
        else if (w_op_ext < -w_lim_ext)
            w_op_sat = -signed'({1'b0, w_vlim});
        else
            w_op_sat = w_operand[20:0];
    end

    // homing speed
    logic [19:0]        w_hs0;
    logic [19:0]        w_hs;
    logic signed [20:0] w_home_tv;
    assign w_hs0     = (r_hspd != '0) ? r_hspd : w_vlim;
    assign w_hs      = (w_hs0 > w_vlim) ? w_vlim : w_hs0;
    assign w_home_tv = s_axis_tdata[15] ? -signed'({1'b0, w_hs}) : signed'({1'b0, w_hs});

    // magnitude of the current velocity
    logic [20:0] w_vabs;
    assign w_vabs = r_vel[20] ? 21'(-r_vel) : 21'(r_vel);

    // serial units
    logic                         w_mul_start;
    logic [tspg_pkg::MUL_A_W-1:0] w_mul_a;
    logic [tspg_pkg::MUL_B_W-1:0] w_mul_b;
    logic                         w_mul_done;
    logic [tspg_pkg::PROD_W-1:0]  w_prod;
    logic                         w_div_start;
    logic [tspg_pkg::PROD_W-1:0]  w_div_num;
    logic [tspg_pkg::DIVR_W-1:0]  w_div_den;
    logic                         w_div_done;
    logic [tspg_pkg::PROD_W-1:0]  w_quo;
    logic [tspg_pkg::DIVR_W-1:0]  w_drem;

    assign w_mul_start = (r_state == ST_MSTART);
    always_comb begin
        case (r_phase)
            PH_DV:   begin w_mul_a = w_accl;           w_mul_b = {5'd0, r_dt}; end
            PH_CAP:  begin w_mul_a = {4'd0, w_vlim};   w_mul_b = {5'd0, r_dt}; end
            PH_DD:   begin w_mul_a = {3'd0, w_vabs};   w_mul_b = w_vabs;       end
            default: begin w_mul_a = {3'd0, w_vabs};   w_mul_b = {5'd0, r_dt}; end
        endcase
    end

    // signed step total: v*dt + remainder
    logic signed [45:0] w_total;
    logic [44:0]        w_tmag;
    assign w_total = r_vel[20] ? (signed'({26'd0, r_frac}) - signed'({1'b0, w_prod}))
                               : (signed'({1'b0, w_prod}) + signed'({26'd0, r_frac}));
    assign w_tmag  = w_total[45] ? 45'(-w_total) : 45'(w_total);

    assign w_div_start = (r_state == ST_MUL) && w_mul_done;
    assign w_div_num   = (r_phase == PH_STEP) ? w_tmag : w_prod;
    assign w_div_den   = (r_phase == PH_DD) ? {1'b0, w_accl, 1'b0}
                                            : {6'd0, tspg_pkg::US_PER_SEC};

    tspg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    tspg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo),
        .o_rem   (w_drem)
    );

    // ramp toward a goal by at most dv
    function automatic logic signed [23:0] ramp_to(
        input logic signed [23:0] v,
        input logic signed [23:0] goal,
        input logic signed [23:0] dv
    );
        logic signed [23:0] up;
        logic signed [23:0] dn;
        up = v + dv;
        dn = v - dv;
        if (v < goal)
            ramp_to = (up > goal) ? goal : up;
        else if (v > goal)
            ramp_to = (dn < goal) ? goal : dn;
        else
            ramp_to = goal;
    endfunction

    // new velocity after ramp and limit
    logic signed [23:0] w_v24;
    logic signed [23:0] w_dv24;
    logic signed [23:0] w_lim24;
    logic signed [23:0] w_tv24;
    logic signed [23:0] w_tvabs24;
    logic signed [23:0] w_cruise;
    logic signed [23:0] w_goal;
    logic signed [23:0] w_up;
    logic signed [23:0] w_dn;
    logic signed [23:0] w_nv;
    logic signed [20:0] n_vel;
    assign w_v24     = 24'(r_vel);
    assign w_dv24    = signed'({3'd0, r_dv});
    assign w_lim24   = signed'({4'd0, w_vlim});
    assign w_tv24    = 24'(r_tvel);
    assign w_tvabs24 = r_tvel[20] ? -w_tv24 : w_tv24;
    assign w_cruise  = (r_tvel == '0 || w_tvabs24 > w_lim24) ? w_lim24 : w_tvabs24;
    assign w_goal    = r_neg ? -w_cruise : w_cruise;
    assign w_up      = w_v24 + w_dv24;
    assign w_dn      = w_v24 - w_dv24;
    always_comb begin
        if (r_mode == tspg_pkg::MODE_POSITION) begin
            if ({9'd0, r_mag} <= r_dd)
                w_nv = ramp_to(w_v24, 24'sd0, w_dv24);
            else if (!r_neg)
                w_nv = (w_v24 < w_goal) ? ((w_up > w_goal) ? w_goal : w_up) : w_goal;
            else
                w_nv = (w_v24 > w_goal) ? ((w_dn < w_goal) ? w_goal : w_dn) : w_goal;
        end else begin
            w_nv = ramp_to(w_v24, w_tv24, w_dv24);
        end
        if (w_nv > w_lim24)
            n_vel = w_lim24[20:0];
        else if (w_nv < -w_lim24)
            n_vel = 21'(-w_lim24);
        else
            n_vel = w_nv[20:0];
    end

    // floor division fix-up, step cap and arrival clamp
    logic signed [19:0] w_q0;
    logic signed [19:0] w_capv;
    logic signed [19:0] n_q;
    logic [19:0]        n_frac;
    logic [19:0]        w_r0;
    logic [19:0]        w_qabs;
    assign w_q0   = signed'(w_quo[19:0]);
    assign w_r0   = w_drem[19:0];
    assign w_capv = signed'({2'd0, r_cap});
    always_comb begin
        if (r_tneg && w_r0 != '0) begin
            n_q    = -(w_q0 + 20'sd1);
            n_frac = tspg_pkg::US_PER_SEC - w_r0;
        end else if (r_tneg) begin
            n_q    = -w_q0;
            n_frac = '0;
        end else begin
            n_q    = w_q0;
            n_frac = w_r0;
        end
        if (n_q > w_capv) begin
            n_q    = w_capv;
            n_frac = '0;
        end else if (n_q < -w_capv) begin
            n_q    = -w_capv;
            n_frac = '0;
        end
        w_qabs = n_q[19] ? 20'(-n_q) : 20'(n_q);
        if (r_mode == tspg_pkg::MODE_POSITION && {12'd0, w_qabs} > r_mag) begin
            if (!r_neg && n_q > 20'sd0) begin
                n_q    = signed'(r_mag[19:0]);
                n_frac = '0;
            end else if (r_neg && n_q < 20'sd0) begin
                n_q    = -signed'(r_mag[19:0]);
                n_frac = '0;
            end
        end
    end

    // configuration writes
    assign o_cfg_ready = 1'b1;

    // sequencer and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_DV;
            r_vmax      <= 20'd1000;
            r_amax      <= 24'd10000;
            r_hspd      <= '0;
            r_mode      <= tspg_pkg::MODE_IDLE;
            r_pos       <= '0;
            r_tgt       <= '0;
            r_vel       <= '0;
            r_tvel      <= '0;
            r_frac      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    tspg_pkg::CFG_MAX_VEL:  r_vmax <= i_cfg_data[19:0];
                    tspg_pkg::CFG_MAX_ACC:  r_amax <= i_cfg_data;
                    tspg_pkg::CFG_HOME_SPD: r_hspd <= i_cfg_data[19:0];
                    default: ;
                endcase
            end

            if (r_out_valid && m_axis_tready && !w_load)
                r_out_valid <= 1'b0;

            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_steps <= '0;
                        r_dt    <= w_dt;
                        r_neg   <= w_rem[31];
                        r_mag   <= w_rem[31] ? (32'd0 - w_rem) : w_rem;
                        unique case (w_op)
                            tspg_pkg::OP_TICK: begin
                                if (r_mode == tspg_pkg::MODE_POSITION) begin
                                    if (w_rem == '0) begin
                                        r_mode  <= tspg_pkg::MODE_IDLE;
                                        r_vel   <= '0;
                                        r_tvel  <= '0;
                                        r_frac  <= '0;
                                        r_state <= ST_LOAD;
                                    end else begin
                                        r_phase <= PH_DV;
                                        r_state <= ST_MSTART;
                                    end
                                end else if (r_mode == tspg_pkg::MODE_IDLE) begin
                                    r_vel   <= '0;
                                    r_state <= ST_LOAD;
                                end else if ((r_mode == tspg_pkg::MODE_HOMING &&
                                              (w_tout || w_sensor)) || r_tvel == '0) begin
                                    if (r_mode == tspg_pkg::MODE_HOMING && !w_tout && w_sensor)
                                        r_pos <= '0;
                                    r_mode  <= tspg_pkg::MODE_IDLE;
                                    r_vel   <= '0;
                                    r_tvel  <= '0;
                                    r_frac  <= '0;
                                    r_state <= ST_LOAD;
                                end else begin
                                    r_phase <= PH_DV;
                                    r_state <= ST_MSTART;
                                end
                            end
                            tspg_pkg::OP_STOP: begin
                                r_mode  <= tspg_pkg::MODE_IDLE;
                                r_vel   <= '0;
                                r_tvel  <= '0;
                                r_frac  <= '0;
                                r_state <= ST_LOAD;
                            end
                            tspg_pkg::OP_MOVE_ABS: begin
                                r_tgt   <= w_operand;
                                r_tvel  <= '0;
                                r_mode  <= tspg_pkg::MODE_POSITION;
                                r_state <= ST_LOAD;
                            end
                            tspg_pkg::OP_MOVE_REL: begin
                                r_tgt   <= r_pos + w_operand;
                                r_tvel  <= '0;
                                r_mode  <= tspg_pkg::MODE_POSITION;
                                r_state <= ST_LOAD;
                            end
                            tspg_pkg::OP_VEL_MOVE: begin
                                r_tvel  <= w_op_sat;
                                r_mode  <= tspg_pkg::MODE_VELOCITY;
                                r_state <= ST_LOAD;
                            end
                            tspg_pkg::OP_HOME: begin
                                r_tvel  <= w_home_tv;
                                r_mode  <= tspg_pkg::MODE_HOMING;
                                r_state <= ST_LOAD;
                            end
                            default: r_state <= ST_LOAD;
                        endcase
                    end
                end
                ST_MSTART: r_state <= ST_MUL;
                ST_MUL: begin
                    if (w_mul_done) begin
                        r_tneg  <= w_total[45];
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        unique case (r_phase)
                            PH_DV: begin
                                r_dv    <= (w_quo == '0) ? 21'd1 : w_quo[20:0];
                                r_phase <= PH_CAP;
                                r_state <= ST_MSTART;
                            end
                            PH_CAP: begin
                                r_cap <= w_quo[17:0] + 18'd1;
                                if (r_mode == tspg_pkg::MODE_POSITION && r_vel != '0) begin
                                    r_phase <= PH_DD;
                                    r_state <= ST_MSTART;
                                end else begin
                                    r_dd    <= '0;
                                    r_state <= ST_RAMP;
                                end
                            end
                            PH_DD: begin
                                r_dd    <= (w_quo == '0) ? 41'd1 : w_quo[40:0];
                                r_state <= ST_RAMP;
                            end
                            default: begin
                                r_steps <= n_q[17:0];
                                r_frac  <= n_frac;
                                r_pos   <= r_pos + 32'(n_q);
                                r_state <= ST_LOAD;
                            end
                        endcase
                    end
                end
                ST_RAMP: begin
                    r_vel   <= n_vel;
                    r_phase <= PH_STEP;
                    r_state <= ST_MSTART;
                end
                ST_LOAD: begin
                    if (w_load) begin
                        r_out_data  <= {6'd0,
                                        (r_mode == tspg_pkg::MODE_IDLE),
                                        r_mode,
                                        r_vel,
                                        r_pos,
                                        r_steps};
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tdata  = r_out_data;
    assign m_axis_tvalid = r_out_valid;

    // checks
    `TSPG_ASSERT_IMP(a_mul_done_in_mul, w_mul_done, r_state == ST_MUL)
    `TSPG_ASSERT_IMP(a_div_done_in_div, w_div_done, r_state == ST_DIV)
    `TSPG_ASSERT_NEXT(a_mul_to_div, r_state == ST_MUL && w_mul_done, r_state == ST_DIV)
    `TSPG_ASSERT_IMP(a_frac_range, 1'b1, r_frac < tspg_pkg::US_PER_SEC)
    `TSPG_ASSERT_IMP(a_idle_still, r_mode == tspg_pkg::MODE_IDLE, r_vel == '0)

endmodule

@@ verif/trapezoidal_step_profile_generator_test.sv @@
// Self-checking testbench for the trapezoidal step profile generator.
// Drives commands and time ticks on the stream input, predicts every result in place.
// Depends on tspg_pkg and the trapezoidal_step_profile_generator RTL.
`timescale 1ns / 1ps

module trapezoidal_step_profile_generator_test;

    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;
    localparam longint     US       = 1000000;
    localparam int         PHASES   = 7;
    localparam int         PER_PHASE = 255;
    localparam int         HOLD_CYCLES = 3000;
    localparam longint     CYCLE_LIMIT = 20000000;

    // field order matches the result tdata, lowest bits last
    typedef struct packed {
        logic        done;
        logic [1:0]  mode;
        logic [20:0] vel;
        logic [31:0] pos;
        logic [17:0] steps;
    } t_motion;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] operand;
        logic [15:0] dt;
        logic        sensor;
        logic        tmo;
        bit          typed;
        t_motion     res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic [55:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;

    trapezoidal_step_profile_generator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // predictor state
    longint          lim_vel = 1000;
    longint          lim_acc = 10000;
    longint          home_spd = 0;
    tspg_pkg::t_mode axis_mode = tspg_pkg::MODE_IDLE;
    logic [31:0]     axis_pos = '0;
    logic [31:0]     goal_pos = '0;
    longint          axis_vel = 0;
    longint          goal_vel = 0;
    longint          frac_acc = 0;

    t_motion     expected_motion[$];
    int          mismatches = 0;
    bit          hold_req = 0;
    longint      cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic longint vel_cap();
        return (lim_vel == 0) ? 1 : lim_vel;
    endfunction

    function automatic longint acc_cap();
        return (lim_acc == 0) ? 1 : lim_acc;
    endfunction

    function automatic longint clamp_vel(longint v);
        if (v > vel_cap()) return vel_cap();
        if (v < -vel_cap()) return -vel_cap();
        return v;
    endfunction

    function automatic longint ramp(longint v, longint goal, longint dv);
        if (v < goal) return (v + dv > goal) ? goal : v + dv;
        if (v > goal) return (v - dv < goal) ? goal : v - dv;
        return goal;
    endfunction

    function automatic void stop_axis();
        axis_mode = tspg_pkg::MODE_IDLE;
        axis_vel  = 0;
        goal_vel  = 0;
        frac_acc  = 0;
    endfunction

    // integrate velocity over dt with sub-step remainder, capped
    function automatic longint integrate_steps(longint v, longint dt);
        longint total, q, r, cap;
        total = v * dt + frac_acc;
        q = total / US;
        r = total % US;
        if (r < 0) begin
            q = q - 1;
            r = r + US;
        end
        frac_acc = r;
        cap = (vel_cap() * dt) / US + 1;
        if (q > cap) begin
            q = cap;
            frac_acc = 0;
        end
        if (q < -cap) begin
            q = -cap;
            frac_acc = 0;
        end
        return q;
    endfunction

    function automatic longint tick_steps(longint dt, bit sensor, bit tmo);
        longint      dv, steps, mag, vabs, brake, cruise, goal, nv;
        logic [31:0] rem;
        bit          neg;
        dv = (acc_cap() * dt) / US;
        if (dv < 1) dv = 1;
        steps = 0;
        if (axis_mode == tspg_pkg::MODE_POSITION) begin
            rem = goal_pos - axis_pos;
            if (rem == 0) begin
                stop_axis();
                return 0;
            end
            neg = rem[31];
            mag = neg ? longint'({32'b0, -rem}) : longint'({32'b0, rem});
            cruise = (goal_vel != 0) ? ((goal_vel < 0) ? -goal_vel : goal_vel) : vel_cap();
            if (cruise > vel_cap()) cruise = vel_cap();
            vabs = (axis_vel < 0) ? -axis_vel : axis_vel;
            brake = 0;
            if (vabs != 0) begin
                brake = (vabs * vabs) / (2 * acc_cap());
                if (brake < 1) brake = 1;
            end
            if (mag <= brake) begin
                nv = ramp(axis_vel, 0, dv);
            end else begin
                goal = neg ? -cruise : cruise;
                if (!neg) nv = (axis_vel < goal) ? ((axis_vel + dv > goal) ? goal : axis_vel + dv) : goal;
                else nv = (axis_vel > goal) ? ((axis_vel - dv < goal) ? goal : axis_vel - dv) : goal;
            end
            axis_vel = clamp_vel(nv);
            steps = integrate_steps(axis_vel, dt);
            // never overshoot the target
            if (!neg && steps > 0 && steps > mag) begin
                steps = mag;
                frac_acc = 0;
            end
            if (neg && steps < 0 && -steps > mag) begin
                steps = -mag;
                frac_acc = 0;
            end
        end else if (axis_mode == tspg_pkg::MODE_HOMING ||
                     axis_mode == tspg_pkg::MODE_VELOCITY) begin
            if (axis_mode == tspg_pkg::MODE_HOMING && tmo) begin
                stop_axis();
                return 0;
            end
            if (axis_mode == tspg_pkg::MODE_HOMING && sensor) begin
                stop_axis();
                axis_pos = '0;
                return 0;
            end
            if (goal_vel == 0) begin
                stop_axis();
                return 0;
            end
            axis_vel = clamp_vel(ramp(axis_vel, goal_vel, dv));
            steps = integrate_steps(axis_vel, dt);
        end else begin
            axis_vel = 0;
        end
        axis_pos = axis_pos + steps[31:0];
        return steps;
    endfunction

    // expected result of one accepted item; advances the predictor state
    function automatic t_motion motion_predict(logic [2:0] op, logic [31:0] operand,
                                               logic [15:0] dt, bit sensor, bit tmo);
        longint  steps, spd;
        t_motion r;
        steps = 0;
        case (op)
            tspg_pkg::OP_TICK:     steps = tick_steps(longint'(dt), sensor, tmo);
            tspg_pkg::OP_STOP:     stop_axis();
            tspg_pkg::OP_MOVE_ABS: begin
                goal_pos  = operand;
                goal_vel  = 0;
                axis_mode = tspg_pkg::MODE_POSITION;
            end
            tspg_pkg::OP_MOVE_REL: begin
                goal_pos  = axis_pos + operand;
                goal_vel  = 0;
                axis_mode = tspg_pkg::MODE_POSITION;
            end
            tspg_pkg::OP_VEL_MOVE: begin
                goal_vel  = clamp_vel(longint'($signed(operand)));
                axis_mode = tspg_pkg::MODE_VELOCITY;
            end
            tspg_pkg::OP_HOME: begin
                spd = (home_spd != 0) ? home_spd : vel_cap();
                if (spd > vel_cap()) spd = vel_cap();
                goal_vel  = operand[15] ? -spd : spd;
                axis_mode = tspg_pkg::MODE_HOMING;
            end
            default: ;
        endcase
        r.steps = steps[17:0];
        r.pos   = axis_pos;
        r.vel   = axis_vel[20:0];
        r.mode  = axis_mode;
        r.done  = (axis_mode == tspg_pkg::MODE_IDLE);
        return r;
    endfunction

    // result side: check each transaction, stall at random
    int ready_stall = 0;
    int ready_calm  = 0;
    int hold_left   = 0;

    always @(posedge i_clk) begin
        t_motion got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[73:0];
            if (expected_motion.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                mismatches++;
            end else begin
                want = expected_motion.pop_front();
                if (got.steps !== want.steps) begin
                    $display("%0t: steps exp %0d got %0d", $time,
                             $signed(want.steps), $signed(got.steps));
                    mismatches++;
                end
                if (got.pos !== want.pos) begin
                    $display("%0t: position exp %0d got %0d", $time,
                             $signed(want.pos), $signed(got.pos));
                    mismatches++;
                end
                if (got.vel !== want.vel) begin
                    $display("%0t: velocity exp %0d got %0d", $time,
                             $signed(want.vel), $signed(got.vel));
                    mismatches++;
                end
                if (got.mode !== want.mode) begin
                    $display("%0t: mode exp %0d got %0d", $time, want.mode, got.mode);
                    mismatches++;
                end
                if (got.done !== want.done) begin
                    $display("%0t: done exp %0d got %0d", $time, want.done, got.done);
                    mismatches++;
                end
            end
        end
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (ready_stall > 0) begin
            ready_stall--;
            m_axis_tready <= 1'b0;
        end else if (ready_calm > 0) begin
            ready_calm--;
            m_axis_tready <= 1'b1;
        end else begin
            case ($urandom_range(0, 99)) inside
                [0:59]:  ready_stall = 0;
                [60:84]: ready_stall = $urandom_range(1, 3);
                [85:94]: ready_stall = $urandom_range(4, 30);
                [95:96]: ready_stall = $urandom_range(100, 600);
                default: ready_calm  = $urandom_range(50, 400);
            endcase
            m_axis_tready <= (ready_stall == 0);
        end
    end

    // offer one item and wait for its transaction; predictor runs at acceptance
    task automatic send_item(logic [2:0] op, logic [31:0] operand, logic [15:0] dt,
                             bit sensor, bit tmo, bit typed, t_motion typed_res, int gap);
        t_motion pred;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {6'b0, tmo, sensor, dt, operand};
        do @(posedge i_clk); while (!s_axis_tready);
        pred = motion_predict(op, operand, dt, sensor, tmo);
        expected_motion.push_back(typed ? typed_res : pred);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_motion.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [23:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            tspg_pkg::CFG_MAX_VEL:  lim_vel  = longint'(data[19:0]);
            tspg_pkg::CFG_MAX_ACC:  lim_acc  = longint'(data);
            tspg_pkg::CFG_HOME_SPD: home_spd = longint'(data[19:0]);
            default: ;
        endcase
    endtask

    function automatic int pick_gap(bit busy);
        if (busy) return 0;
        case ($urandom_range(0, 99)) inside
            [0:59]:  return 0;
            [60:89]: return $urandom_range(1, 3);
            [90:97]: return $urandom_range(4, 25);
            default: return $urandom_range(50, 300);
        endcase
    endfunction

    function automatic logic [15:0] pick_dt();
        case ($urandom_range(0, 99)) inside
            [0:79]:  return 16'($urandom_range(50, 2000));
            [80:93]: return 16'($urandom_range(0, 50));
            default: return 16'($urandom());
        endcase
    endfunction

    // directed rows: typed results only where the state is plain to see
    t_row rows[$];

    function automatic t_row row(logic [2:0] op, logic [31:0] operand, logic [15:0] dt,
                                 bit sensor, bit tmo, bit typed, t_motion res);
        t_row r;
        r.op = op; r.operand = operand; r.dt = dt; r.sensor = sensor; r.tmo = tmo;
        r.typed = typed; r.res = res;
        return r;
    endfunction

    initial begin
        t_motion     idle0, none;
        logic [2:0]  op;
        logic [31:0] operand;
        logic [23:0] vel_set[PHASES];
        logic [23:0] acc_set[PHASES];
        logic [23:0] home_set[PHASES];
        bit          busy;
        int          sel;

        idle0 = '{steps: '0, pos: '0, vel: '0, mode: tspg_pkg::MODE_IDLE, done: 1'b1};
        none  = idle0;
        // out of reset: idle state, unknown opcodes, command-only rows
        rows.push_back(row(tspg_pkg::OP_TICK, 32'h0, 16'h0, 0, 0, 1, idle0));
        rows.push_back(row(OP_RSVD6, 32'hFFFFFFFF, 16'hFFFF, 1, 1, 1, idle0));
        rows.push_back(row(OP_RSVD7, 32'h0, 16'h0, 0, 0, 1, idle0));
        rows.push_back(row(tspg_pkg::OP_STOP, 32'h1234, 16'h0, 0, 0, 1, idle0));
        rows.push_back(row(tspg_pkg::OP_MOVE_ABS, 32'h7FFFFFFF, 16'h0, 0, 0, 1,
                           '{steps: '0, pos: '0, vel: '0, mode: tspg_pkg::MODE_POSITION,
                             done: 1'b0}));
        rows.push_back(row(tspg_pkg::OP_MOVE_REL, 32'hFFFFFFFB, 16'h0, 0, 0, 1,
                           '{steps: '0, pos: '0, vel: '0, mode: tspg_pkg::MODE_POSITION,
                             done: 1'b0}));
        rows.push_back(row(tspg_pkg::OP_VEL_MOVE, 32'h80000000, 16'h0, 0, 0, 1,
                           '{steps: '0, pos: '0, vel: '0, mode: tspg_pkg::MODE_VELOCITY,
                             done: 1'b0}));
        rows.push_back(row(tspg_pkg::OP_HOME, 32'h00008000, 16'h0, 0, 0, 1,
                           '{steps: '0, pos: '0, vel: '0, mode: tspg_pkg::MODE_HOMING,
                             done: 1'b0}));
        rows.push_back(row(tspg_pkg::OP_STOP, 32'h0, 16'h0, 0, 0, 1, idle0));
        // predicted rows: moves, arrival, velocity extremes, homing exits
        rows.push_back(row(tspg_pkg::OP_MOVE_REL, 32'd20, 16'h0, 0, 0, 0, none));
        rows.push_back(row(tspg_pkg::OP_TICK, 32'h0, 16'hFFFF, 0, 0, 0, none));
        rows.push_back(row(tspg_pkg::OP_TICK, 32'h0, 16'hFFFF, 0, 0, 0, none));
        rows.push_back(row(tspg_pkg::OP_TICK, 32'h0, 16'h0, 0, 0, 0, none));
        rows.push_back(row(tspg_pkg::OP_TICK, 32'h0, 16'd1000, 0, 0, 0, none));
        rows.push_back(row(tspg_pkg::OP_VEL_MOVE, 32'h7FFFFFFF, 16'h0, 0, 0, 0, none));
        rows.push_back(row(tspg_pkg::OP_TICK, 32'h0, 16'hFFFF, 0, 0, 0, none));
        rows.push_back(row(tspg_pkg::OP_TICK, 32'h0, 16'hFFFF, 1, 1, 0, none));
        rows.push_back(row(tspg_pkg::OP_VEL_MOVE, 32'h0, 16'h0, 0, 0, 0, none));
        rows.push_back(row(tspg_pkg::OP_TICK, 32'h0, 16'd500, 0, 0, 0, none));
        rows.push_back(row(tspg_pkg::OP_HOME, 32'h00000001, 16'h0, 0, 0, 0, none));
        rows.push_back(row(tspg_pkg::OP_TICK, 32'h0, 16'd50000, 0, 0, 0, none));
        rows.push_back(row(tspg_pkg::OP_TICK, 32'h0, 16'd200, 1, 0, 0, none));
        rows.push_back(row(tspg_pkg::OP_HOME, 32'hFFFF0FFF, 16'h0, 0, 0, 0, none));
        rows.push_back(row(tspg_pkg::OP_TICK, 32'h0, 16'd40000, 0, 0, 0, none));
        rows.push_back(row(tspg_pkg::OP_TICK, 32'h0, 16'd200, 0, 1, 0, none));
        rows.push_back(row(tspg_pkg::OP_TICK, 32'hFFFFFFFF, 16'hFFFF, 0, 0, 0, none));

        // register settings per phase, extremes among them
        vel_set  = '{24'd1000, 24'd1, 24'd0, 24'd1000000, 24'hFFFFF, 24'd5000, 24'd200};
        acc_set  = '{24'd10000, 24'd1, 24'd0, 24'd10000000, 24'hFFFFFF, 24'd200000, 24'd50};
        home_set = '{24'd0, 24'd0, 24'd5, 24'd1000000, 24'hFFFFF, 24'd300, 24'd2000};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k])
            send_item(rows[k].op, rows[k].operand, rows[k].dt, rows[k].sensor, rows[k].tmo,
                      rows[k].typed, rows[k].res, pick_gap(0));

        for (int ph = 0; ph < PHASES; ph++) begin
            // every pause here also waits for all results of the previous phase
            drain();
            cfg_write(tspg_pkg::CFG_MAX_VEL, vel_set[ph]);
            cfg_write(tspg_pkg::CFG_MAX_ACC, acc_set[ph]);
            cfg_write(tspg_pkg::CFG_HOME_SPD, home_set[ph]);
            busy = (ph == 3);
            for (int n = 0; n < PER_PHASE; n++) begin
                if (ph == 2 && n == 40) hold_req = 1;
                sel = $urandom_range(0, 99);
                if (sel < 66) begin
                    op = tspg_pkg::OP_TICK;
                    operand = $urandom();
                end else if (sel < 74) begin
                    op = tspg_pkg::OP_MOVE_REL;
                    operand = ($urandom_range(0, 9) == 0) ? 32'($urandom())
                            : 32'($signed($urandom_range(0, 4000)) - 2000);
                end else if (sel < 80) begin
                    op = tspg_pkg::OP_MOVE_ABS;
                    operand = ($urandom_range(0, 9) == 0) ? 32'($urandom())
                            : axis_pos + 32'($signed($urandom_range(0, 4000)) - 2000);
                end else if (sel < 87) begin
                    op = tspg_pkg::OP_VEL_MOVE;
                    operand = ($urandom_range(0, 4) == 0) ? 32'($urandom())
                            : 32'($signed($urandom_range(0, 4 * vel_set[ph] + 2))
                                  - 2 * vel_set[ph] - 1);
                end else if (sel < 93) begin
                    op = tspg_pkg::OP_HOME;
                    operand = $urandom();
                end else if (sel < 98) begin
                    op = tspg_pkg::OP_STOP;
                    operand = $urandom();
                end else begin
                    op = ($urandom_range(0, 1) != 0) ? OP_RSVD6 : OP_RSVD7;
                    operand = $urandom();
                end
                send_item(op, operand, pick_dt(), ($urandom_range(0, 29) == 0),
                          ($urandom_range(0, 29) == 0), 0, idle0, pick_gap(busy));
            end
        end

        drain();
        if (mismatches == 0 && expected_motion.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
